// ===== rtl/mfhic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfhic_pkg
// Shared types and constants of the magnetometer filter and hard-iron block.
// ----------------------------------------------------------------------------
package mfhic_pkg;

  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Operation carried by each input beat
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_SAVE   = 2'd2,
    OP_LOAD   = 2'd3
  } op_e;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFS_X = 3'd0,
    REG_OFS_Y = 3'd1,
    REG_OFS_Z = 3'd2,
    REG_SCL_X = 3'd3,
    REG_SCL_Y = 3'd4,
    REG_SCL_Z = 3'd5
  } cfg_reg_e;

  // Min/max seeds loaded by a start of calibration
  localparam logic signed [FIELD_W-1:0] CAL_MIN_START = 16'sd8000;
  localparam logic signed [FIELD_W-1:0] CAL_MAX_START = -16'sd8000;

  // Per-stage strobes shared by all axis lanes
  typedef struct packed {
    logic acc_smp;   // sample beat accepted: write ring, read old entry
    logic ld2_smp;   // sample enters running-sum stage
    logic ld3;       // magnitude stage loads
    logic ld4;       // reciprocal product stage loads
    logic ld5;       // mean stage loads
    logic ld6_smp;   // sample enters gain stage
    logic op_start;  // start calibration takes effect
    logic op_save;   // save calibration takes effect
    logic op_load;   // load stored offsets and scales
    logic mm_upd;    // fold the finished value into min/max
  } lane_ctl_t;

  // One result beat
  typedef struct packed {
    logic signed [FIELD_W-1:0] field_x;
    logic signed [FIELD_W-1:0] field_y;
    logic signed [FIELD_W-1:0] field_z;
    logic                      calibrating;
  } out_beat_t;

endpackage
`default_nettype wire

// ===== rtl/mfhic_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfhic_lane
// One axis: history ring with running sum, mean by reciprocal multiply,
// offset and gain, round toward zero, saturation and min/max capture.
// ----------------------------------------------------------------------------
module mfhic_lane #(
  parameter int unsigned DEPTH           = 10,
  parameter int unsigned SCALE_FRAC_BITS = 12,
  localparam int unsigned SLOT_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire mfhic_pkg::lane_ctl_t                      ctl_i,
  input  wire logic [SLOT_W-1:0]                         slot_i,
  input  wire logic signed [mfhic_pkg::FIELD_W-1:0]      wr_val_i,
  input  wire logic signed [mfhic_pkg::FIELD_W-1:0]      stored_offset_i,
  input  wire logic [mfhic_pkg::FIELD_W-1:0]             stored_scale_i,
  output logic signed [mfhic_pkg::FIELD_W-1:0]           val_o
);

  localparam int unsigned FW      = mfhic_pkg::FIELD_W;
  localparam int unsigned CLOG_D  = $clog2(DEPTH);
  localparam int unsigned ABS_W   = FW + CLOG_D;
  localparam int unsigned SUM_W   = ABS_W + 1;
  localparam int unsigned DIV_SH  = ABS_W + CLOG_D + 1;
  localparam int unsigned RECIP_W = DIV_SH + 1;
  localparam int unsigned QP_W    = ABS_W + RECIP_W;
  localparam int unsigned QUO_W   = FW + 1;
  localparam int unsigned PROD_W  = 2 * (FW + 1);
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << DIV_SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));
  localparam logic [FW-1:0] UNITY = FW'(64'd1 << SCALE_FRAC_BITS);
  localparam logic signed [PROD_W-1:0] RND_BIAS =
      PROD_W'((64'd1 << SCALE_FRAC_BITS) - 64'd1);
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(32768);

  // History ring
  logic signed [FW-1:0] ring_mem [DEPTH];
  logic [DEPTH-1:0]     ring_vld_q;
  logic signed [FW-1:0] new_q;
  logic signed [FW-1:0] old_q;
  logic                 old_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc_smp) begin
      ring_mem[slot_i] <= wr_val_i;
      old_q            <= ring_mem[slot_i];
      new_q            <= wr_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
      old_vld_q  <= 1'b0;
    end else if (ctl_i.acc_smp) begin
      ring_vld_q[slot_i] <= 1'b1;
      old_vld_q          <= ring_vld_q[slot_i];
    end
  end

  // Running sum: add the new entry, drop the one it replaces
  logic signed [SUM_W-1:0] sum_q, sum_d, old_ext;

  always_comb begin
    old_ext = old_vld_q ? SUM_W'(old_q) : '0;
    sum_d   = sum_q + SUM_W'(new_q) - old_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctl_i.ld2_smp) begin
      sum_q <= sum_d;
    end
  end

  // Mean: magnitude, multiply by reciprocal, restore sign
  logic [ABS_W-1:0]     abs_q;
  logic                 neg3_q, neg4_q;
  logic [QP_W-1:0]      qp_q;
  logic [QUO_W-1:0]     quo;
  logic signed [FW-1:0] mean_q;

  assign quo = qp_q[DIV_SH +: QUO_W];

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld3) begin
      abs_q  <= sum_q[SUM_W-1] ? ABS_W'(-sum_q) : ABS_W'(sum_q);
      neg3_q <= sum_q[SUM_W-1];
    end
    if (ctl_i.ld4) begin
      qp_q   <= QP_W'(abs_q) * QP_W'(RECIP);
      neg4_q <= neg3_q;
    end
    if (ctl_i.ld5) begin
      mean_q <= neg4_q ? FW'(-quo) : FW'(quo);
    end
  end

  // Offset, gain and calibration state
  logic signed [FW-1:0] offset_q;
  logic [FW-1:0]        scale_q;
  logic signed [FW-1:0] min_q, max_q;
  logic signed [FW:0]   mm_sum;
  logic signed [FW:0]   mid;

  always_comb begin
    mm_sum = (FW+1)'(min_q) + (FW+1)'(max_q);
    mid    = (mm_sum + (FW+1)'(mm_sum[FW])) >>> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      scale_q  <= UNITY;
    end else if (ctl_i.op_start) begin
      offset_q <= '0;
      scale_q  <= UNITY;
    end else if (ctl_i.op_save) begin
      offset_q <= FW'(mid);
    end else if (ctl_i.op_load) begin
      offset_q <= stored_offset_i;
      scale_q  <= stored_scale_i;
    end
  end

  // Gain stage
  logic signed [FW:0]       diff, scl_s;
  logic signed [PROD_W-1:0] prod_q;

  always_comb begin
    diff  = (FW+1)'(mean_q) - (FW+1)'(offset_q);
    scl_s = {1'b0, scale_q};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld6_smp) begin
      prod_q <= diff * scl_s;
    end
  end

  // Drop fraction bits toward zero, then clamp
  logic signed [PROD_W-1:0] rnd, shd;

  always_comb begin
    rnd = prod_q + (prod_q[PROD_W-1] ? RND_BIAS : '0);
    shd = rnd >>> SCALE_FRAC_BITS;
    if (shd > SAT_HI) begin
      val_o = 16'sh7fff;
    end else if (shd < SAT_LO) begin
      val_o = -16'sh8000;
    end else begin
      val_o = FW'(shd);
    end
  end

  // Start reseeds; a capturing sample widens the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
    end else if (ctl_i.op_start) begin
      min_q <= mfhic_pkg::CAL_MIN_START;
      max_q <= mfhic_pkg::CAL_MAX_START;
    end else if (ctl_i.mm_upd) begin
      if (val_o < min_q) min_q <= val_o;
      if (val_o > max_q) max_q <= val_o;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mfhic_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfhic_merge
// Collect the three lane values and the capture flag into one output beat.
// ----------------------------------------------------------------------------
module mfhic_merge (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 ld_i,
  input  wire logic signed [mfhic_pkg::FIELD_W-1:0] val_x_i,
  input  wire logic signed [mfhic_pkg::FIELD_W-1:0] val_y_i,
  input  wire logic signed [mfhic_pkg::FIELD_W-1:0] val_z_i,
  input  wire logic                                 cal_i,
  input  wire logic                                 out_ready_i,
  output logic                                      free_o,
  output logic                                      out_valid_o,
  output mfhic_pkg::out_beat_t                      beat_o
);

  logic                 valid_q, valid_d;
  mfhic_pkg::out_beat_t beat_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ld_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      beat_q.field_x     <= val_x_i;
      beat_q.field_y     <= val_y_i;
      beat_q.field_z     <= val_z_i;
      beat_q.calibrating <= cal_i;
    end
  end

  assign out_valid_o = valid_q;
  assign beat_o      = beat_q;

endmodule
`default_nettype wire

// ===== rtl/magnetometer_filter_and_hard_iron_cal_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A sample beat reaches the output through every stage and the merge register.
// Throughput: one beat per cycle without back-pressure; a start or save beat
// waits behind a capturing sample that has not yet updated min/max.
// Reset: asynchronous, clears all control state; rings read as zero through
// per-entry valid bits, offsets go to zero and scales to unity at once.
// ----------------------------------------------------------------------------
// magnetometer_filter_and_hard_iron_cal_top
// Three-axis magnetometer smoothing with min/max hard-iron calibration.
// Three axis lanes run side by side; a merge stage builds the result beat.
// ----------------------------------------------------------------------------
module magnetometer_filter_and_hard_iron_cal_top #(
  parameter int unsigned DEPTH           = 10,
  parameter int unsigned SCALE_FRAC_BITS = 12
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // input beats
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic [1:0]                             op_i,
  input  wire logic signed [mfhic_pkg::FIELD_W-1:0]   raw_x_i,
  input  wire logic signed [mfhic_pkg::FIELD_W-1:0]   raw_y_i,
  input  wire logic signed [mfhic_pkg::FIELD_W-1:0]   raw_z_i,
  // result beats
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed [mfhic_pkg::FIELD_W-1:0]        field_x_o,
  output logic signed [mfhic_pkg::FIELD_W-1:0]        field_y_o,
  output logic signed [mfhic_pkg::FIELD_W-1:0]        field_z_o,
  output logic                                        calibrating_o,
  // register writes
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [mfhic_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [mfhic_pkg::FIELD_W-1:0]          cfg_data_i
);

  localparam int unsigned FW     = mfhic_pkg::FIELD_W;
  localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [FW-1:0] UNITY = FW'(64'd1 << SCALE_FRAC_BITS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DEPTH - 1);

  // --------------------------------------------------------------------------
  // Configuration registers: always ready, read only by a load beat.
  // --------------------------------------------------------------------------
  logic signed [FW-1:0] stored_offset_q [3];
  logic [FW-1:0]        stored_scale_q  [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        stored_offset_q[a] <= '0;
        stored_scale_q[a]  <= UNITY;
      end
    end else if (cfg_valid_i) begin
      unique case (mfhic_pkg::cfg_reg_e'(cfg_index_i))
        mfhic_pkg::REG_OFS_X: stored_offset_q[0] <= cfg_data_i;
        mfhic_pkg::REG_OFS_Y: stored_offset_q[1] <= cfg_data_i;
        mfhic_pkg::REG_OFS_Z: stored_offset_q[2] <= cfg_data_i;
        mfhic_pkg::REG_SCL_X: stored_scale_q[0]  <= cfg_data_i;
        mfhic_pkg::REG_SCL_Y: stored_scale_q[1]  <= cfg_data_i;
        mfhic_pkg::REG_SCL_Z: stored_scale_q[2]  <= cfg_data_i;
        default: ;  // indexes past the map are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. Stage 1 holds the ring read, 2 the running sum,
  // 3 the magnitude, 4 the reciprocal product, 5 the mean, 6 the gain
  // product. Control beats ride along and act when they leave stage 5,
  // the point where offsets, scales and the capture flag live; they
  // produce no result and vanish there. Each stage advances when the next
  // is empty or moving (5 bar ctl_wait); bubbles collapse under back-pressure.
  // --------------------------------------------------------------------------
  logic            v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic            v1_d, v2_d, v3_d, v4_d, v5_d, v6_d;
  mfhic_pkg::op_e  op1_q, op2_q, op3_q, op4_q, op5_q;
  mfhic_pkg::op_e  op_in;
  logic            cap6_q;
  logic            capture_q, capture_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic out_free, mv6, free6, ctl_wait;
  logic take1, take2, take3, take4, take5;
  logic free1, free2, free3, free4, free5;
  logic acc;
  logic op5_smp;

  mfhic_pkg::lane_ctl_t lane_ctl;

  assign op_in   = mfhic_pkg::op_e'(op_i);
  assign op5_smp = (op5_q == mfhic_pkg::OP_SAMPLE);

  always_comb begin
    mv6   = v6_q && out_free;
    free6 = !v6_q || out_free;
    // Hold start and save until the capturing sample ahead has folded
    // its value into min/max.
    ctl_wait = v5_q && v6_q && cap6_q &&
               (op5_q == mfhic_pkg::OP_START || op5_q == mfhic_pkg::OP_SAVE);
    take5 = v5_q && free6 && !ctl_wait;
    free5 = !v5_q || take5;
    take4 = v4_q && free5;
    free4 = !v4_q || take4;
    take3 = v3_q && free4;
    free3 = !v3_q || take3;
    take2 = v2_q && free3;
    free2 = !v2_q || take2;
    take1 = v1_q && free2;
    free1 = !v1_q || take1;
    in_ready_o = free1;
    acc        = in_valid_i && free1;
  end

  always_comb begin
    v1_d = acc   ? 1'b1 : (take1 ? 1'b0 : v1_q);
    v2_d = take1 ? 1'b1 : (take2 ? 1'b0 : v2_q);
    v3_d = take2 ? 1'b1 : (take3 ? 1'b0 : v3_q);
    v4_d = take3 ? 1'b1 : (take4 ? 1'b0 : v4_q);
    v5_d = take4 ? 1'b1 : (take5 ? 1'b0 : v5_q);
    v6_d = (take5 && op5_smp) ? 1'b1 : (mv6 ? 1'b0 : v6_q);

    capture_d = capture_q;
    if (take5 && op5_q == mfhic_pkg::OP_START) begin
      capture_d = 1'b1;
    end else if (take5 && op5_q == mfhic_pkg::OP_SAVE) begin
      capture_d = 1'b0;
    end

    // Advance the shared write slot once per accepted sample
    slot_d = slot_q;
    if (acc && op_in == mfhic_pkg::OP_SAMPLE) begin
      slot_d = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      capture_q <= 1'b0;
      slot_q    <= '0;
    end else begin
      v1_q      <= v1_d;
      v2_q      <= v2_d;
      v3_q      <= v3_d;
      v4_q      <= v4_d;
      v5_q      <= v5_d;
      v6_q      <= v6_d;
      capture_q <= capture_d;
      slot_q    <= slot_d;
    end
  end

  // Op tags and the capture flag travel with their beat
  always_ff @(posedge clk_i) begin
    if (acc)   op1_q <= op_in;
    if (take1) op2_q <= op1_q;
    if (take2) op3_q <= op2_q;
    if (take3) op4_q <= op3_q;
    if (take4) op5_q <= op4_q;
    if (take5 && op5_smp) cap6_q <= capture_q;
  end

  // Strobes shared by the three lanes
  always_comb begin
    lane_ctl.acc_smp  = acc && (op_in == mfhic_pkg::OP_SAMPLE);
    lane_ctl.ld2_smp  = take1 && (op1_q == mfhic_pkg::OP_SAMPLE);
    lane_ctl.ld3      = take2;
    lane_ctl.ld4      = take3;
    lane_ctl.ld5      = take4;
    lane_ctl.ld6_smp  = take5 && op5_smp;
    lane_ctl.op_start = take5 && (op5_q == mfhic_pkg::OP_START);
    lane_ctl.op_save  = take5 && (op5_q == mfhic_pkg::OP_SAVE);
    lane_ctl.op_load  = take5 && (op5_q == mfhic_pkg::OP_LOAD);
    lane_ctl.mm_upd   = mv6 && cap6_q;
  end

  // --------------------------------------------------------------------------
  // Axis lanes. X and Y are mounted inverted: negate with 16-bit wrap.
  // --------------------------------------------------------------------------
  logic signed [FW-1:0] wr_val   [3];
  logic signed [FW-1:0] lane_val [3];

  assign wr_val[0] = FW'(-raw_x_i);
  assign wr_val[1] = FW'(-raw_y_i);
  assign wr_val[2] = raw_z_i;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    mfhic_lane #(
      .DEPTH           (DEPTH),
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_lane (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .ctl_i           (lane_ctl),
      .slot_i          (slot_q),
      .wr_val_i        (wr_val[g]),
      .stored_offset_i (stored_offset_q[g]),
      .stored_scale_i  (stored_scale_q[g]),
      .val_o           (lane_val[g])
    );
  end

  // --------------------------------------------------------------------------
  // Merge: register one result beat, parting the pipeline from the consumer.
  // --------------------------------------------------------------------------
  mfhic_pkg::out_beat_t beat;

  mfhic_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (mv6),
    .val_x_i     (lane_val[0]),
    .val_y_i     (lane_val[1]),
    .val_z_i     (lane_val[2]),
    .cal_i       (cap6_q),
    .out_ready_i (out_ready_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .beat_o      (beat)
  );

  assign field_x_o     = beat.field_x;
  assign field_y_o     = beat.field_y;
  assign field_z_o     = beat.field_z;
  assign calibrating_o = beat.calibrating;

endmodule
`default_nettype wire
